@@ rtl/taatc_pkg.sv @@
`timescale 1ns / 1ps
package taatc_pkg;
  localparam int MAX_DIMS_DEF   = 4;
  localparam int LIST_DEPTH_DEF = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam logic [31:0] TILE_WORD_BYTES = 32'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] REG_NUM_DIMS     = 3'd0;
  localparam logic [2:0] REG_AXIS_SIZES   = 3'd1;
  localparam logic [2:0] REG_TILE_EXTENTS = 3'd2;
  localparam logic [2:0] REG_HEADER_BYTES = 3'd3;
  localparam logic [2:0] REG_LIST_LIMIT   = 3'd4;

  typedef struct packed {
    logic [2:0]  coord_count;
    logic [15:0] coord_0;
    logic [15:0] coord_1;
    logic [15:0] coord_2;
    logic [15:0] coord_3;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  bad_axis;
    logic        hit;
    logic [31:0] tile_linear;
    logic [31:0] tile_offset;
    logic [31:0] tile_byte_offset;
    logic        evicted_valid;
    logic [31:0] evicted_tile;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  bad_axis;
    logic [31:0] tile_linear;
    logic [31:0] tile_offset;
    logic [31:0] tile_byte_offset;
  } mid_word_t;
endpackage

@@ rtl/taatc_ram.sv @@
`timescale 1ns / 1ps
module taatc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/taatc_front.sv @@
`timescale 1ns / 1ps
module taatc_front #(
  parameter int MAX_DIMS   = taatc_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS = taatc_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  taatc_pkg::in_word_t   din,
  input  logic [2:0]            num_dims,
  input  logic [63:0]           axis_sizes,
  input  logic [63:0]           tile_extents,
  input  logic [15:0]           header_bytes,
  output logic                  mvalid,
  input  logic                  mready,
  output taatc_pkg::mid_word_t  mword
);
  import taatc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state;
  logic [1:0]  axis;
  logic [4:0]  bitc;
  logic [15:0] coords [4];
  logic [15:0] quo, rem;
  logic [15:0] ext, asz;
  logic [31:0] tnum, tpos, stride, bufstride, words;
  logic [15:0] sq;          // size / extent
  logic [15:0] srem;
  mid_word_t   res;
  logic        last;
  logic [16:0] rtry, strry;
  logic [COORD_BITS-1:0] cm [4];
  logic [1:0]  chk_status, chk_axis;

  assign full   = (state != S_IDLE);
  assign mvalid = (state == S_DONE);
  assign mword  = res;
  assign ext = tile_extents[16*axis +: 16];
  assign asz = axis_sizes[16*axis +: 16];
  assign last = ({1'b0, axis} + 3'd1 == num_dims);
  assign rtry  = {rem, coords[axis][bitc[3:0]]} - {1'b0, ext};
  assign strry = {srem, asz[bitc[3:0]]} - {1'b0, ext};

  always_comb begin
    cm[0] = din.coord_0[COORD_BITS-1:0];
    cm[1] = din.coord_1[COORD_BITS-1:0];
    cm[2] = din.coord_2[COORD_BITS-1:0];
    cm[3] = din.coord_3[COORD_BITS-1:0];
  end

  // classify the incoming word: count first, then the lowest axis out of range
  always_comb begin
    chk_status = ST_OK;
    chk_axis   = 2'd0;
    if (num_dims < 3'd1 || 32'(num_dims) > MAX_DIMS ||
        din.coord_count != num_dims) begin
      chk_status = ST_COUNT;
    end else begin
      priority if (16'(cm[0]) >= axis_sizes[15:0]) begin
        chk_status = ST_RANGE; chk_axis = 2'd0;
      end else if (num_dims > 3'd1 && 16'(cm[1]) >= axis_sizes[31:16]) begin
        chk_status = ST_RANGE; chk_axis = 2'd1;
      end else if (num_dims > 3'd2 && 16'(cm[2]) >= axis_sizes[47:32]) begin
        chk_status = ST_RANGE; chk_axis = 2'd2;
      end else if (num_dims > 3'd3 && 16'(cm[3]) >= axis_sizes[63:48]) begin
        chk_status = ST_RANGE; chk_axis = 2'd3;
      end else begin
        chk_status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            res <= '{status: chk_status, bad_axis: chk_axis, default: '0};
            for (int k = 0; k < 4; k++) begin
              coords[k] <= 16'(cm[k]);
            end
            tnum <= '0; tpos <= '0; stride <= 32'd1; bufstride <= 32'd1; words <= 32'd1;
            axis <= '0; bitc <= 5'd15; quo <= '0; rem <= '0; sq <= '0; srem <= '0;
            state <= (chk_status == ST_OK) ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle, coord and size together
          if (!rtry[16]) begin
            rem <= rtry[15:0]; quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= {rem[14:0], coords[axis][bitc[3:0]]}; quo <= {quo[14:0], 1'b0};
          end
          if (!strry[16]) begin
            srem <= strry[15:0]; sq <= {sq[14:0], 1'b1};
          end else begin
            srem <= {srem[14:0], asz[bitc[3:0]]}; sq <= {sq[14:0], 1'b0};
          end
          if (bitc == 5'd0) begin
            state <= S_ACC;
          end
          bitc <= bitc - 5'd1;
        end
        S_ACC: begin
          if (ext == 16'd0) begin
            tpos <= tpos + 32'(coords[axis]) * bufstride;
          end else begin
            tnum <= tnum + 32'(quo) * stride;
            tpos <= tpos + 32'(rem) * bufstride;
            stride <= stride * 32'(sq);
          end
          if (ext == 16'd0) begin
            stride <= '0;
          end
          bufstride <= bufstride * 32'(ext);
          words <= words * 32'(ext);
          quo <= '0; rem <= '0; sq <= '0; srem <= '0; bitc <= 5'd15;
          if (last) begin
            state <= S_MUL;
          end else begin
            axis <= axis + 2'd1;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          res.tile_linear <= tnum;
          res.tile_offset <= tpos;
          res.tile_byte_offset <= 32'(header_bytes) + tnum * (words << 2);
          state <= S_DONE;
        end
        S_DONE: begin
          if (mready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/taatc_back.sv @@
`timescale 1ns / 1ps
module taatc_back #(
  parameter int LIST_DEPTH = taatc_pkg::LIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mvalid,
  output logic                  mready,
  input  taatc_pkg::mid_word_t  mword,
  input  logic [4:0]            list_limit,
  output logic                  empty,
  input  logic                  pop,
  output taatc_pkg::out_word_t  dout
);
  import taatc_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 2);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHF  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // list held as work: slot 0 is the old current tag, slot j+1 is ram[j]
  logic [2:0]    state;
  logic          cur_valid;
  logic [31:0]   cur_tag;
  logic [CW-1:0] rcount, n, j, limit;
  logic          found;
  logic [31:0]   carry;
  mid_word_t     m;
  out_word_t     rb;
  out_word_t     ob;
  logic          ob_full;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [31:0]   ev;
  logic          ev_set;

  taatc_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign mready = (state == S_IDLE) && mvalid;
  assign empty  = !ob_full;
  assign dout   = ob;
  assign limit  = (32'(list_limit) > LIST_DEPTH) ? CW'(LIST_DEPTH) : CW'(list_limit);
  assign raddr  = AW'(j);

  // walk: in S_RD read ram[j]; in S_CMP, until the hit, write carry into ram[j]
  // (shift down by one, the hit entry is overwritten) and take ram[j] as next carry.
  // Without a hit the last carry lands in ram[rcount] when the list may grow.
  always_comb begin
    we = 1'b0; waddr = AW'(j); wdata = carry;
    if (state == S_CMP && !found) begin
      we = 1'b1;
    end else if (state == S_FIN && !found && n <= limit) begin
      we = 1'b1; waddr = AW'(rcount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cur_valid <= 1'b0; cur_tag <= '0; rcount <= '0; ob_full <= 1'b0;
    end else begin
      if (state == S_OUT && (!ob_full || pop)) begin
        ob_full <= 1'b1;
      end else if (pop) begin
        ob_full <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (mvalid) begin
            m <= mword; found <= 1'b0; j <= '0; carry <= cur_tag; ev <= '0; ev_set <= 1'b0;
            if (mword.status != ST_OK) begin
              rb <= '{status: mword.status, bad_axis: mword.bad_axis, default: '0};
              state <= S_OUT;
            end else if (!cur_valid || cur_tag == mword.tile_linear) begin
              rb <= '{status: ST_OK, bad_axis: 2'd0, hit: cur_valid,
                      tile_linear: mword.tile_linear, tile_offset: mword.tile_offset,
                      tile_byte_offset: mword.tile_byte_offset, default: '0};
              cur_valid <= 1'b1; cur_tag <= mword.tile_linear;
              state <= S_OUT;
            end else begin
              n <= rcount + CW'(1);
              state <= (rcount == '0) ? S_FIN : S_RD;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (!found && rdata == m.tile_linear) begin
            found <= 1'b1;
          end else begin
            carry <= rdata;
          end
          if (j + CW'(1) >= rcount) begin
            state <= S_FIN;
          end else begin
            j <= j + CW'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          // carry holds the oldest entry of the new list
          if ((found ? n - CW'(1) : n) > limit) begin
            ev <= carry;
            ev_set <= 1'b1;
            n <= limit;
            state <= S_SHF;
          end else begin
            n <= found ? n - CW'(1) : n;
            state <= S_SHF;
          end
        end
        S_SHF: begin
          // ram now holds the new list; entries beyond n are ignored thereafter
          rcount <= n;
          cur_valid <= 1'b1; cur_tag <= m.tile_linear;
          rb <= '{status: ST_OK, bad_axis: 2'd0, hit: found,
                  tile_linear: m.tile_linear, tile_offset: m.tile_offset,
                  tile_byte_offset: m.tile_byte_offset,
                  evicted_valid: ev_set, evicted_tile: ev};
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ob_full || pop) begin
            ob <= rb;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/tiled_array_address_and_tile_cache.sv @@
`timescale 1ns / 1ps
// Tiled array address unit with a most-recently-used tile list.
// Input channel: push/full carries one coordinate word (count and four axis
// indices). Result channel: empty/pop presents the oldest result word (status,
// tile index, in-tile offset, file byte offset, hit and eviction).
// Configuration: cfg_we/cfg_index/cfg_data write one register a cycle, idle only.
// The block does not itself enforce the idle-only rule; the user must keep it.
// An error word passes from the front straight to the back's result register.
// A good point is divided per axis (a 16-bit quotient for tile index and for
// tile count, then an accumulate step), then the byte offset is formed. If its
// tile is current or no tile is held, the back answers at once; otherwise it
// walks the recent list in the list RAM, a read and a compare per entry, then
// finishes and shifts. The front takes the next word once the back has taken
// the previous one; the back walks the list for one word while the front
// divides for the next, so the slower of the two sets the pace.
// Reset clears the current tile and list count; the list RAM needs no clearing.
// A stalled receiver holds the result word; the back stops, then the front.
module tiled_array_address_and_tile_cache #(
  parameter int MAX_DIMS   = taatc_pkg::MAX_DIMS_DEF,
  parameter int LIST_DEPTH = taatc_pkg::LIST_DEPTH_DEF,
  parameter int COORD_BITS = taatc_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  taatc_pkg::in_word_t  din,
  output logic                 empty,
  input  logic                 pop,
  output taatc_pkg::out_word_t dout,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import taatc_pkg::*;

  logic [2:0]  num_dims;
  logic [63:0] axis_sizes, tile_extents;
  logic [15:0] header_bytes;
  logic [4:0]  list_limit;
  logic        mvalid, mready;
  mid_word_t   mword;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 3'd1; axis_sizes <= '0; tile_extents <= '0;
      header_bytes <= '0; list_limit <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_DIMS:     num_dims     <= cfg_data[2:0];
        REG_AXIS_SIZES:   axis_sizes   <= cfg_data;
        REG_TILE_EXTENTS: tile_extents <= cfg_data;
        REG_HEADER_BYTES: header_bytes <= cfg_data[15:0];
        REG_LIST_LIMIT:   list_limit   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  taatc_front #(.MAX_DIMS(MAX_DIMS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din),
    .num_dims(num_dims), .axis_sizes(axis_sizes), .tile_extents(tile_extents),
    .header_bytes(header_bytes), .mvalid(mvalid), .mready(mready), .mword(mword)
  );

  taatc_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk(clk), .rst(rst), .mvalid(mvalid), .mready(mready), .mword(mword),
    .list_limit(list_limit), .empty(empty), .pop(pop), .dout(dout)
  );
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import taatc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_word_t    din = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_word_t   dout;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_NUM_DIMS;
  logic [63:0] cfg_data = '0;

  tiled_array_address_and_tile_cache dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din),
    .empty(empty), .pop(pop), .dout(dout),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block's registers and tile cache
  logic [2:0]  m_dims;
  logic [63:0] m_sizes, m_extents;
  logic [15:0] m_header;
  logic [4:0]  m_limit;
  logic        m_cur_valid = 1'b0;
  logic [31:0] m_cur_tag = '0;
  logic [31:0] m_recent[16];
  int          m_recent_n = 0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        failures = 0;
  bit        calm;      // no idling in the final stretch
  bit        hold_send; // sender waits for every result before the next word

  function automatic logic [31:0] q32(logic [31:0] a, logic [31:0] b);
    return (b == 0) ? 32'd0 : a / b;
  endfunction

  // Compute the result word for one point and advance the cache shadow
  function automatic out_word_t predict_tile_access(in_word_t w);
    out_word_t r;
    logic [15:0] c[4];
    logic [31:0] tnum, tpos, stride, bstride, words, ext, sz, tidx;
    logic [31:0] work[17];
    int n, lim;
    bit found;
    r = '0;
    c[0] = w.coord_0; c[1] = w.coord_1; c[2] = w.coord_2; c[3] = w.coord_3;
    if (m_dims < 1 || m_dims > 4 || w.coord_count != m_dims) begin
      r.status = ST_COUNT;
      return r;
    end
    for (int i = 0; i < m_dims; i++) begin
      if (c[i] >= m_sizes[16*i +: 16]) begin
        r.status = ST_RANGE;
        r.bad_axis = i[1:0];
        return r;
      end
    end
    tnum = 0; tpos = 0; stride = 1; bstride = 1; words = 1;
    for (int i = 0; i < m_dims; i++) begin
      ext = {16'd0, m_extents[16*i +: 16]};
      sz = {16'd0, m_sizes[16*i +: 16]};
      tidx = q32({16'd0, c[i]}, ext);
      tnum += tidx * stride;
      tpos += ({16'd0, c[i]} - tidx * ext) * bstride;
      stride *= q32(sz, ext);
      bstride *= ext;
      words *= ext;
    end
    if (m_cur_valid && m_cur_tag == tnum) begin
      r.hit = 1'b1;
    end else if (m_cur_valid) begin
      work[0] = m_cur_tag;
      for (int j = 0; j < m_recent_n; j++) work[j+1] = m_recent[j];
      n = m_recent_n + 1;
      m_cur_valid = 1'b0;
      found = 1'b0;
      for (int j = 0; j < n && !found; j++) begin
        if (work[j] == tnum) begin
          found = 1'b1;
          m_cur_tag = tnum;
          m_cur_valid = 1'b1;
          r.hit = 1'b1;
          for (int k = j; k + 1 < n; k++) work[k] = work[k+1];
        end
      end
      if (found) n--;
      lim = (m_limit > 16) ? 16 : m_limit;
      if (n > lim) begin
        r.evicted_valid = 1'b1;
        r.evicted_tile = work[n-1];
        n = lim;
      end
      for (int j = 0; j < n; j++) m_recent[j] = work[j];
      m_recent_n = n;
    end
    if (!m_cur_valid) begin
      m_cur_tag = tnum;
      m_cur_valid = 1'b1;
    end
    r.tile_linear = tnum;
    r.tile_offset = tpos;
    r.tile_byte_offset = {16'd0, m_header} + tnum * (TILE_WORD_BYTES * words);
    return r;
  endfunction

  // Driver: present queued words, with random gaps between them
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) begin
        expected_words.push_back(predict_tile_access(din));
        void'(pending_words.pop_front());
      end
      if (push && full) begin
        // hold the word until accepted
      end else if (send_gap > 0) begin
        push <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        send_gap <= $urandom_range(0, 3);
      end else if (pending_words.size() > 0 &&
                   !(hold_send && expected_words.size() > 0)) begin
        push <= 1'b1;
        din <= pending_words[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: pop with random stalls and compare each whole word with the expected one
  int pop_gap;
  out_word_t exp_w;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, dout);
          failures++;
        end else begin
          exp_w = expected_words.pop_front();
          if (dout !== exp_w) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_w, dout);
            failures++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        pop_gap <= $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_DIMS:     m_dims = val[2:0];
      REG_AXIS_SIZES:   m_sizes = val;
      REG_TILE_EXTENTS: m_extents = val;
      REG_HEADER_BYTES: m_header = val[15:0];
      REG_LIST_LIMIT:   m_limit = val[4:0];
      default: ;
    endcase
  endtask

  // Wait until every queued word is sent and answered, then let the back settle
  task automatic drain();
    while (pending_words.size() > 0 || expected_words.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic in_word_t make_point(logic [2:0] cnt, bit inrange);
    in_word_t w;
    logic [15:0] c[4];
    logic [15:0] s;
    for (int i = 0; i < 4; i++) begin
      s = m_sizes[16*i +: 16];
      if (inrange && s != 0 && $urandom_range(0, 15) != 0)
        c[i] = 16'($urandom_range(0, s - 1));
      else
        c[i] = 16'($urandom);
    end
    w.coord_count = cnt;
    w.coord_0 = c[0]; w.coord_1 = c[1]; w.coord_2 = c[2]; w.coord_3 = c[3];
    return w;
  endfunction

  function automatic logic [63:0] pack4(int a, int b, int c, int d);
    return {d[15:0], c[15:0], b[15:0], a[15:0]};
  endfunction

  // Random phase; small tile grids so the cache hits often; limit may drop midway
  task automatic run_phase(int nwords);
    logic [2:0] d;
    int ext, sz;
    logic [63:0] sizes, exts;
    d = 3'($urandom_range(1, 4));
    sizes = '0; exts = '0;
    for (int i = 0; i < 4; i++) begin
      ext = $urandom_range(1, 8);
      sz = ext * $urandom_range(1, 3) + $urandom_range(0, ext - 1);
      if ($urandom_range(0, 9) == 0) ext = 0;
      if ($urandom_range(0, 19) == 0) begin
        sz = $urandom_range(0, 65535); ext = $urandom_range(0, 65535);
      end
      sizes[16*i +: 16] = 16'(sz); exts[16*i +: 16] = 16'(ext);
    end
    write_reg(REG_NUM_DIMS,
              ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 7)) : 64'(d));
    write_reg(REG_AXIS_SIZES, sizes);
    write_reg(REG_TILE_EXTENTS, exts);
    write_reg(REG_HEADER_BYTES, 64'($urandom));
    write_reg(REG_LIST_LIMIT, 64'($urandom_range(0, 31)));
    for (int k = 0; k < nwords; k++) begin
      // mostly well-formed points; some wrong counts and out-of-range coords
      if ($urandom_range(0, 9) == 0)
        pending_words.push_back(make_point(3'($urandom_range(0, 7)), 1'b0));
      else
        pending_words.push_back(make_point(m_dims, $urandom_range(0, 5) != 0));
      // lower the limit mid-phase sometimes to force multiple drops
      if (k == nwords / 2 && $urandom_range(0, 1) == 1) begin
        drain();
        write_reg(REG_LIST_LIMIT, 64'($urandom_range(0, 3)));
      end
    end
    drain();
  endtask

  initial begin
    m_dims = 3'd1; m_sizes = '0; m_extents = '0; m_header = '0; m_limit = 5'd16;
    calm = 1'b0; hold_send = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset config (all sizes zero), then extremes
    pending_words.push_back('{3'd1, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_words.push_back('{3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();
    write_reg(REG_NUM_DIMS, 64'd4);
    write_reg(REG_AXIS_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_TILE_EXTENTS, pack4(1, 0, 16'hFFFF, 7));
    write_reg(REG_HEADER_BYTES, 64'hFFFF);
    write_reg(REG_LIST_LIMIT, 64'd31);
    pending_words.push_back('{3'd4, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE});
    pending_words.push_back('{3'd4, 16'hFFFF, 16'd0, 16'd0, 16'd0});
    pending_words.push_back('{3'd4, 16'd0, 16'd0, 16'd0, 16'hFFFF});
    pending_words.push_back('{3'd4, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_words.push_back('{3'd4, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_words.push_back('{3'd4, 16'd1, 16'd5, 16'd9, 16'd8});
    pending_words.push_back('{3'd7, 16'd0, 16'd0, 16'd0, 16'd0});
    pending_words.push_back('{3'd3, 16'd0, 16'd0, 16'd0, 16'd0});
    drain();
    // Dimension counts outside the supported range
    write_reg(REG_NUM_DIMS, 64'd7);
    pending_words.push_back('{3'd7, 16'd0, 16'd0, 16'd0, 16'd0});
    drain();
    write_reg(REG_NUM_DIMS, 64'd0);
    pending_words.push_back('{3'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    drain();

    // Random phases; one waits for every result before resuming
    for (int p = 0; p < 26; p++) begin
      if (p == 25) calm = 1'b1;
      if (p == 10) begin
        hold_send = 1'b1;
        run_phase(1);
        hold_send = 1'b0;
      end
      run_phase(50);
    end
    drain();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
rtl/taatc_pkg.sv
rtl/taatc_ram.sv
rtl/taatc_front.sv
rtl/taatc_back.sv
rtl/tiled_array_address_and_tile_cache.sv
tb/tb_top.sv
